/* design/mtbu_pkg.sv */
// ----------------------------------------------------------------------------
// mtbu_pkg
// Shared types and constants of the Metropolis triplet bond update pipeline.
// ----------------------------------------------------------------------------
package mtbu_pkg;

  // energies are signed Q8.8 in kT
  typedef logic signed [15:0] energy_t;

  // result codes
  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_REDRAW   = 2'd2,
    ST_BAD_LINK = 2'd3
  } status_t;

  // proposed state
  typedef enum logic [1:0] {
    PROP_AB   = 2'd0,
    PROP_BC   = 2'd1,
    PROP_AC   = 2'd2,
    PROP_NONE = 2'd3
  } prop_t;

  // allowed link patterns {ab, bc, ac}
  localparam logic [2:0] PAT_ALL   = 3'b111;
  localparam logic [2:0] PAT_NO_BC = 3'b101;
  localparam logic [2:0] PAT_NO_AB = 3'b011;
  localparam logic [2:0] PAT_NO_AC = 3'b110;

  // exp(-de) is evaluated for 0 < de < 2^DeBits (Q8.8), else saturates
  localparam int unsigned DeBits      = 12;
  localparam int unsigned TermCount   = 13;
  localparam int unsigned SquareCount = 4;

  typedef struct packed {
    logic          bond_ab;
    logic          bond_bc;
    logic          bond_ac;
    logic          link_ab;
    logic          link_bc;
    logic          link_ac;
    energy_t       energy_ab;
    energy_t       energy_bc;
    energy_t       energy_ac;
    logic [15:0]   uniform_draw;
    prop_t         proposal;
  } in_word_t;

  // decision side band that rides along with the exp datapath
  typedef struct packed {
    logic [2:0]  cur;
    logic [2:0]  take;
    status_t     status;
    logic        use_exp;
    logic [15:0] draw;
  } side_t;

  // series state: energy step, last Taylor term, running sum (Q0.32)
  typedef struct packed {
    logic [DeBits-1:0] d;
    logic [31:0]       term;
    logic [31:0]       acc;
  } exp_t;

  typedef struct packed {
    side_t side;
    exp_t  ex;
  } pipe_t;

endpackage

/* design/mtbu_in_if.sv */
// ----------------------------------------------------------------------------
// mtbu_in_if
// Input word channel of the bond update core: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface mtbu_in_if;
  logic        valid;
  logic        ready;
  logic        bond_ab;
  logic        bond_bc;
  logic        bond_ac;
  logic        link_ab;
  logic        link_bc;
  logic        link_ac;
  logic signed [15:0] energy_ab;
  logic signed [15:0] energy_bc;
  logic signed [15:0] energy_ac;
  logic [15:0] uniform_draw;
  logic [1:0]  proposal;

  modport source (
    output valid, bond_ab, bond_bc, bond_ac, link_ab, link_bc, link_ac,
           energy_ab, energy_bc, energy_ac, uniform_draw, proposal,
    input  ready
  );

  modport sink (
    input  valid, bond_ab, bond_bc, bond_ac, link_ab, link_bc, link_ac,
           energy_ab, energy_bc, energy_ac, uniform_draw, proposal,
    output ready
  );
endinterface

/* design/mtbu_out_if.sv */
// ----------------------------------------------------------------------------
// mtbu_out_if
// Result word channel of the bond update core: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface mtbu_out_if;
  logic       valid;
  logic       ready;
  logic       next_ab;
  logic       next_bc;
  logic       next_ac;
  logic [1:0] status;

  modport source (
    output valid, next_ab, next_bc, next_ac, status,
    input  ready
  );

  modport sink (
    input  valid, next_ab, next_bc, next_ac, status,
    output ready
  );
endinterface

/* design/mtbu_front.sv */
// ----------------------------------------------------------------------------
// mtbu_front
// Two stages: link check and energy sums, then energy step and early decision.
// ----------------------------------------------------------------------------
module mtbu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mtbu_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mtbu_pkg::pipe_t   out_data
);
  import mtbu_pkg::*;

  typedef struct packed {
    side_t              side;
    logic               arith;
    logic signed [17:0] e_cur;
    energy_t            after;
  } f1_t;

  logic  f1_v_r, f2_v_r;
  f1_t   f1_r, f1_nxt;
  pipe_t f2_r, f2_nxt;
  logic  en1, en2;

  logic [2:0]         pattern;
  logic               link_ok, forbid_hit;
  logic signed [17:0] e_ab_x, e_bc_x, e_ac_x;
  logic signed [18:0] de;
  logic               de_le0, de_big;
  logic [DeBits-1:0]  d, neg_d;

  assign en2      = !f2_v_r || out_ready;
  assign en1      = !f1_v_r || en2;
  assign in_ready = en1;

  // stage 1: connectivity, proposal check, energy before and after
  always_comb begin
    pattern    = {in_data.link_ab, in_data.link_bc, in_data.link_ac};
    link_ok    = 1'b1;
    forbid_hit = 1'b0;
    case (pattern)
      PAT_ALL:   forbid_hit = 1'b0;
      PAT_NO_BC: forbid_hit = (in_data.proposal == PROP_BC);
      PAT_NO_AB: forbid_hit = (in_data.proposal == PROP_AB);
      PAT_NO_AC: forbid_hit = (in_data.proposal == PROP_AC);
      default:   link_ok    = 1'b0;
    endcase

    e_ab_x = in_data.bond_ab ? 18'($signed(in_data.energy_ab)) : '0;
    e_bc_x = in_data.bond_bc ? 18'($signed(in_data.energy_bc)) : '0;
    e_ac_x = in_data.bond_ac ? 18'($signed(in_data.energy_ac)) : '0;

    f1_nxt.e_cur = e_ab_x + e_bc_x + e_ac_x;
    case (in_data.proposal)
      PROP_AB: f1_nxt.after = in_data.energy_ab;
      PROP_BC: f1_nxt.after = in_data.energy_bc;
      PROP_AC: f1_nxt.after = in_data.energy_ac;
      default: f1_nxt.after = '0;
    endcase

    f1_nxt.side.cur     = {in_data.bond_ab, in_data.bond_bc, in_data.bond_ac};
    f1_nxt.side.take    = {in_data.proposal == PROP_AB, in_data.proposal == PROP_BC,
                           in_data.proposal == PROP_AC};
    f1_nxt.side.draw    = in_data.uniform_draw;
    f1_nxt.side.use_exp = 1'b0;
    f1_nxt.arith        = link_ok && !forbid_hit;
    if (!link_ok) begin
      f1_nxt.side.status = ST_BAD_LINK;
    end else if (forbid_hit) begin
      f1_nxt.side.status = ST_REDRAW;
    end else begin
      f1_nxt.side.status = ST_ACCEPTED;
    end
  end

  // stage 2: energy step, saturating cases, series seed
  always_comb begin
    de     = 19'($signed(f1_r.after)) - 19'(f1_r.e_cur);
    de_le0 = de[18] || (de == '0);
    de_big = !de[18] && (de[17:DeBits] != '0);
    d      = de[DeBits-1:0];
    neg_d  = '0 - d;

    f2_nxt.side = f1_r.side;
    if (f1_r.arith) begin
      if (de_le0) begin
        f2_nxt.side.status = ST_ACCEPTED;
      end else if (de_big) begin
        f2_nxt.side.status = ST_REJECTED;
      end else begin
        f2_nxt.side.use_exp = 1'b1;
      end
    end
    // first term is d/4096 in Q0.32, sum starts at 1 - d/4096
    f2_nxt.ex.d    = d;
    f2_nxt.ex.term = {d, (32 - DeBits)'(0)};
    f2_nxt.ex.acc  = {neg_d, (32 - DeBits)'(0)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      if (en1) f1_v_r <= in_valid;
      if (en2) f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) f1_r <= f1_nxt;
    if (en2) f2_r <= f2_nxt;
  end

  assign out_valid = f2_v_r;
  assign out_data  = f2_r;

endmodule

/* design/mtbu_term.sv */
// ----------------------------------------------------------------------------
// mtbu_term
// One Taylor term of exp(-w): term_k = term_(k-1) * d / (4096 * K), truncated,
// folded into the alternating sum. Three stages: multiply, reciprocal, fix-up.
// ----------------------------------------------------------------------------
module mtbu_term #(
  parameter int unsigned K = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mtbu_pkg::pipe_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output mtbu_pkg::pipe_t out_data
);
  import mtbu_pkg::*;

  localparam int unsigned ProdW     = 32 + DeBits;
  localparam logic [63:0] RecipWide = (64'd1 << 32) / K;
  localparam logic [31:0] Recip     = 32'(RecipWide);
  localparam logic [31:0] KWord     = 32'(K);
  localparam bit          OddTerm   = (K % 2) == 1;

  logic a_v_r, b_v_r, c_v_r;
  logic en_a, en_b, en_c;

  logic [ProdW-1:0] a_prod_r, a_prod_nxt;
  pipe_t            a_r;
  logic [31:0]      b_q_r, b_q_nxt;
  logic [63:0]      b_m_r, b_m_nxt;
  pipe_t            b_r;
  pipe_t            c_r, c_nxt;

  logic [31:0] qe, rem, term_k;

  assign en_c     = !c_v_r || out_ready;
  assign en_b     = !b_v_r || en_c;
  assign en_a     = !a_v_r || en_b;
  assign in_ready = en_a;

  assign a_prod_nxt = ProdW'(in_data.ex.term) * ProdW'(in_data.ex.d);

  // quotient estimate by reciprocal, low by at most one
  assign b_q_nxt = a_prod_r[ProdW-1:DeBits];
  assign b_m_nxt = 64'(b_q_nxt) * 64'(Recip);

  always_comb begin
    qe     = b_m_r[63:32];
    rem    = b_q_r - qe * KWord;
    term_k = (rem >= KWord) ? qe + 32'd1 : qe;
    c_nxt         = b_r;
    c_nxt.ex.term = term_k;
    c_nxt.ex.acc  = OddTerm ? b_r.ex.acc - term_k : b_r.ex.acc + term_k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (en_a) a_v_r <= in_valid;
      if (en_b) b_v_r <= a_v_r;
      if (en_c) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_prod_r <= a_prod_nxt;
      a_r      <= in_data;
    end
    if (en_b) begin
      b_q_r <= b_q_nxt;
      b_m_r <= b_m_nxt;
      b_r   <= a_r;
    end
    if (en_c) c_r <= c_nxt;
  end

  assign out_valid = c_v_r;
  assign out_data  = c_r;

endmodule

/* design/mtbu_square.sv */
// ----------------------------------------------------------------------------
// mtbu_square
// One squaring of the Q0.32 series value: z = (z * z) >> 32, registered.
// ----------------------------------------------------------------------------
module mtbu_square (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mtbu_pkg::pipe_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output mtbu_pkg::pipe_t out_data
);
  import mtbu_pkg::*;

  logic        sq_v_r;
  pipe_t       sq_r, sq_nxt;
  logic [63:0] prod;
  logic        en;

  assign en       = !sq_v_r || out_ready;
  assign in_ready = en;

  always_comb begin
    prod          = 64'(in_data.ex.acc) * 64'(in_data.ex.acc);
    sq_nxt        = in_data;
    sq_nxt.ex.acc = prod[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else if (en) begin
      sq_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) sq_r <= sq_nxt;
  end

  assign out_valid = sq_v_r;
  assign out_data  = sq_r;

endmodule

/* design/metropolis_triplet_bond_update_core.sv */
// ----------------------------------------------------------------------------
// metropolis_triplet_bond_update_core
// Metropolis accept/reject of one proposed bond state among three sites.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the output is not stalled and returns one
// result word per input word, in order, through two front stages (link
// check, energy sums, energy step), twelve Taylor term units of three stages
// each (multiply by the step, multiply by the reciprocal of the term index,
// remainder fix-up and summation), four squaring stages, and the output
// register with the draw compare. The term chain sets the latency.
// Every stage has its own valid bit and advances when the stage after it is
// empty or moving, so a stalled output only holds the words behind it and
// bubbles still close up while a result waits.
module metropolis_triplet_bond_update_core (
  input logic      clk,
  input logic      rst_n,
  mtbu_in_if.sink  in_ch,
  mtbu_out_if.source out_ch
);
  import mtbu_pkg::*;

  localparam int unsigned NumTerm = TermCount - 1;
  localparam int unsigned NumLink = 1 + NumTerm + SquareCount;

  in_word_t            in_word;
  pipe_t               lnk_data  [NumLink];
  logic [NumLink-1:0]  lnk_valid;
  logic [NumLink-1:0]  lnk_ready;

  logic        out_valid_r;
  logic [2:0]  out_next_r, out_next_nxt;
  status_t     out_status_r, out_status_nxt;
  logic        res_en;
  pipe_t       res_in;
  logic        exp_win;

  assign in_word.bond_ab      = in_ch.bond_ab;
  assign in_word.bond_bc      = in_ch.bond_bc;
  assign in_word.bond_ac      = in_ch.bond_ac;
  assign in_word.link_ab      = in_ch.link_ab;
  assign in_word.link_bc      = in_ch.link_bc;
  assign in_word.link_ac      = in_ch.link_ac;
  assign in_word.energy_ab    = in_ch.energy_ab;
  assign in_word.energy_bc    = in_ch.energy_bc;
  assign in_word.energy_ac    = in_ch.energy_ac;
  assign in_word.uniform_draw = in_ch.uniform_draw;
  assign in_word.proposal     = prop_t'(in_ch.proposal);

  mtbu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_word),
    .out_valid (lnk_valid[0]),
    .out_ready (lnk_ready[0]),
    .out_data  (lnk_data[0])
  );

  for (genvar i = 0; i < NumTerm; i++) begin : g_term
    mtbu_term #(
      .K (i + 2)
    ) u_term (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (lnk_valid[i]),
      .in_ready  (lnk_ready[i]),
      .in_data   (lnk_data[i]),
      .out_valid (lnk_valid[i+1]),
      .out_ready (lnk_ready[i+1]),
      .out_data  (lnk_data[i+1])
    );
  end

  for (genvar s = 0; s < SquareCount; s++) begin : g_square
    mtbu_square u_square (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (lnk_valid[NumTerm+s]),
      .in_ready  (lnk_ready[NumTerm+s]),
      .in_data   (lnk_data[NumTerm+s]),
      .out_valid (lnk_valid[NumTerm+s+1]),
      .out_ready (lnk_ready[NumTerm+s+1]),
      .out_data  (lnk_data[NumTerm+s+1])
    );
  end

  // output register: exp(-de) in Q0.16 against the draw
  assign res_en                = !out_valid_r || out_ch.ready;
  assign lnk_ready[NumLink-1]  = res_en;
  assign res_in                = lnk_data[NumLink-1];

  always_comb begin
    exp_win        = res_in.ex.acc[31:16] > res_in.side.draw;
    out_status_nxt = res_in.side.status;
    if (res_in.side.use_exp) begin
      out_status_nxt = exp_win ? ST_ACCEPTED : ST_REJECTED;
    end
    out_next_nxt = (out_status_nxt == ST_ACCEPTED) ? res_in.side.take : res_in.side.cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_en) begin
      out_valid_r <= lnk_valid[NumLink-1];
    end
  end

  always_ff @(posedge clk) begin
    if (res_en) begin
      out_next_r   <= out_next_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.next_ab = out_next_r[2];
  assign out_ch.next_bc = out_next_r[1];
  assign out_ch.next_ac = out_next_r[0];
  assign out_ch.status  = out_status_r;

endmodule

/* design/mtbu_checker.sv */
// ----------------------------------------------------------------------------
// mtbu_checker
// Port-level checks of the bond update core, bound to the top level.
// ----------------------------------------------------------------------------
module mtbu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_next,
  input logic [1:0] out_status
);
  import mtbu_pkg::*;

  // a word on the output stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // an accepted proposal leaves at most one bond set
  a_accept_bonds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ACCEPTED |-> $onehot0(out_next))
    else $error("accepted word with more than one bond");

  // input back-pressure only when the output itself is blocked
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("output word right after reset");

  // input valid is only observed; it feeds the take signal checked below
  logic in_take;
  assign in_take = in_valid && in_ready;

  a_take_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> in_ready)
    else $error("input taken without ready");

endmodule

bind metropolis_triplet_bond_update_core mtbu_checker u_mtbu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_next   ({out_ch.next_ab, out_ch.next_bc, out_ch.next_ac}),
  .out_status (out_ch.status)
);

/* sim/metropolis_triplet_bond_update_core_tb.sv */
// ----------------------------------------------------------------------------
// metropolis_triplet_bond_update_core_tb
// Streams bond update proposals through the core with random gaps and output
// stalls, predicts every result word in a scoreboard and compares in order.
// ----------------------------------------------------------------------------
module metropolis_triplet_bond_update_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtbu_pkg::*;

  localparam int unsigned RandomWords   = 1800;
  localparam int unsigned DrainCycles   = 60;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned MaxReported   = 10;

  typedef struct {
    logic    next_ab;
    logic    next_bc;
    logic    next_ac;
    status_t status;
  } bond_result_t;

  class bond_update_scoreboard;
    bond_result_t pending_updates[$];
    int unsigned  mismatches;

    // exp(-d/256) in Q0.16 via a truncated series and four squarings
    static function logic [15:0] boltzmann_q16(logic [DeBits-1:0] d);
      logic [63:0] term;
      logic [63:0] pos_sum;
      logic [63:0] neg_sum;
      logic [63:0] z;
      term    = 64'd1 << 32;
      pos_sum = term;
      neg_sum = 64'd0;
      for (int k = 1; k <= TermCount; k++) begin
        term = (term * 64'(d)) / (64'd4096 * 64'(k));
        if (k % 2 == 1) begin
          neg_sum += term;
        end else begin
          pos_sum += term;
        end
      end
      z = pos_sum - neg_sum;
      repeat (SquareCount) z = (z * z) >> 32;
      return z[31:16];
    endfunction

    static function bond_result_t predict_update(in_word_t w);
      bond_result_t r;
      logic [2:0]   links;
      logic         has_ban;
      prop_t        banned;
      int           e_old;
      int           e_new;
      int           de;
      logic         take;
      links     = {w.link_ab, w.link_bc, w.link_ac};
      r.next_ab = w.bond_ab;
      r.next_bc = w.bond_bc;
      r.next_ac = w.bond_ac;
      has_ban   = 1'b1;
      banned    = PROP_NONE;
      case (links)
        PAT_NO_BC: banned = PROP_BC;
        PAT_NO_AB: banned = PROP_AB;
        PAT_NO_AC: banned = PROP_AC;
        default:   has_ban = 1'b0;
      endcase
      if (!(links == PAT_ALL || has_ban)) begin
        r.status = ST_BAD_LINK;
      end else if (has_ban && w.proposal == banned) begin
        r.status = ST_REDRAW;
      end else begin
        e_old = 0;
        if (w.bond_ab) e_old += int'(w.energy_ab);
        if (w.bond_bc) e_old += int'(w.energy_bc);
        if (w.bond_ac) e_old += int'(w.energy_ac);
        case (w.proposal)
          PROP_AB: e_new = int'(w.energy_ab);
          PROP_BC: e_new = int'(w.energy_bc);
          PROP_AC: e_new = int'(w.energy_ac);
          default: e_new = 0;
        endcase
        de = e_new - e_old;
        if (de <= 0) begin
          take = 1'b1;
        end else if (de >= (1 << DeBits)) begin
          take = 1'b0;
        end else begin
          take = boltzmann_q16(de[DeBits-1:0]) > w.uniform_draw;
        end
        if (take) begin
          r.status  = ST_ACCEPTED;
          r.next_ab = (w.proposal == PROP_AB);
          r.next_bc = (w.proposal == PROP_BC);
          r.next_ac = (w.proposal == PROP_AC);
        end else begin
          r.status = ST_REJECTED;
        end
      end
      return r;
    endfunction

    function void note_proposal(in_word_t w);
      pending_updates.push_back(predict_update(w));
    endfunction

    function void check_update(bond_result_t got);
      bond_result_t want;
      if (pending_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("%0t: result word with nothing pending: bonds %b%b%b status %0d",
                   $realtime, got.next_ab, got.next_bc, got.next_ac, got.status);
        return;
      end
      want = pending_updates.pop_front();
      if (got.next_ab !== want.next_ab || got.next_bc !== want.next_bc ||
          got.next_ac !== want.next_ac || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("%0t: mismatch: expected bonds %b%b%b status %0d, got %b%b%b status %0d",
                   $realtime, want.next_ab, want.next_bc, want.next_ac, want.status,
                   got.next_ab, got.next_bc, got.next_ac, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic calm_send;
  logic calm_recv;
  int unsigned quiet_cycles;

  bond_update_scoreboard sb;

  mtbu_in_if  in_ch();
  mtbu_out_if out_ch();

  metropolis_triplet_bond_update_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned idle_gap(logic calm);
    if (calm) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic in_word_t pack_word(logic [2:0] bonds, logic [2:0] links,
                                         int eab, int ebc, int eac, int draw,
                                         prop_t p);
    in_word_t w;
    {w.bond_ab, w.bond_bc, w.bond_ac} = bonds;
    {w.link_ab, w.link_bc, w.link_ac} = links;
    w.energy_ab    = energy_t'(eab);
    w.energy_bc    = energy_t'(ebc);
    w.energy_ac    = energy_t'(eac);
    w.uniform_draw = 16'(draw);
    w.proposal     = p;
    return w;
  endfunction

  function automatic in_word_t random_word();
    logic [2:0] links;
    logic [2:0] bonds;
    int         pick;
    int         e[3];
    pick = $urandom_range(0, 9);
    // mostly legal link patterns so the energy test gets exercised
    case ($urandom_range(0, 3))
      0:       links = PAT_ALL;
      1:       links = PAT_NO_BC;
      2:       links = PAT_NO_AB;
      default: links = PAT_NO_AC;
    endcase
    if (pick >= 8) links = 3'($urandom());
    case ($urandom_range(0, 4))
      0:       bonds = 3'b100;
      1:       bonds = 3'b010;
      2:       bonds = 3'b001;
      3:       bonds = 3'b000;
      default: bonds = 3'($urandom());
    endcase
    // narrow energies keep de inside the series range most of the time
    foreach (e[i]) begin
      if (pick < 7) e[i] = int'($urandom_range(0, 4096)) - 2048;
      else e[i] = int'($urandom_range(0, 65535));
    end
    return pack_word(bonds, links, e[0], e[1], e[2], $urandom_range(0, 65535),
                     prop_t'($urandom_range(0, 3)));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(in_word_t w);
    int unsigned gap;
    gap = idle_gap(calm_send);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.bond_ab      <= w.bond_ab;
    in_ch.bond_bc      <= w.bond_bc;
    in_ch.bond_ac      <= w.bond_ac;
    in_ch.link_ab      <= w.link_ab;
    in_ch.link_bc      <= w.link_bc;
    in_ch.link_ac      <= w.link_ac;
    in_ch.energy_ab    <= w.energy_ab;
    in_ch.energy_bc    <= w.energy_bc;
    in_ch.energy_ac    <= w.energy_ac;
    in_ch.uniform_draw <= w.uniform_draw;
    in_ch.proposal     <= w.proposal;
    in_ch.valid        <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending_updates.size() != 0);
  endtask

  // result side
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = idle_gap(calm_recv);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    in_word_t     w;
    bond_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        w = pack_word({in_ch.bond_ab, in_ch.bond_bc, in_ch.bond_ac},
                      {in_ch.link_ab, in_ch.link_bc, in_ch.link_ac},
                      in_ch.energy_ab, in_ch.energy_bc, in_ch.energy_ac,
                      in_ch.uniform_draw, prop_t'(in_ch.proposal));
        sb.note_proposal(w);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.next_ab = out_ch.next_ab;
        got.next_bc = out_ch.next_bc;
        got.next_ac = out_ch.next_ac;
        got.status  = status_t'(out_ch.status);
        sb.check_update(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_word_t directed[$];
    sb           = new();
    quiet_cycles = 0;
    calm_send    = 1'b0;
    calm_recv    = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.bond_ab      = 1'b0;
    in_ch.bond_bc      = 1'b0;
    in_ch.bond_ac      = 1'b0;
    in_ch.link_ab      = 1'b0;
    in_ch.link_bc      = 1'b0;
    in_ch.link_ac      = 1'b0;
    in_ch.energy_ab    = '0;
    in_ch.energy_bc    = '0;
    in_ch.energy_ac    = '0;
    in_ch.uniform_draw = '0;
    in_ch.proposal     = '0;

    // invalid link patterns
    directed.push_back(pack_word(3'b100, 3'b000, 256, 0, 0, 0, PROP_NONE));
    directed.push_back(pack_word(3'b010, 3'b001, 0, 256, 0, 0, PROP_AC));
    directed.push_back(pack_word(3'b001, 3'b010, 0, 0, 256, 0, PROP_BC));
    directed.push_back(pack_word(3'b000, 3'b100, -256, 0, 0, 0, PROP_AB));
    // forbidden proposals
    directed.push_back(pack_word(3'b000, PAT_NO_BC, 0, -512, 0, 0, PROP_BC));
    directed.push_back(pack_word(3'b000, PAT_NO_AB, -512, 0, 0, 0, PROP_AB));
    directed.push_back(pack_word(3'b000, PAT_NO_AC, 0, 0, -512, 0, PROP_AC));
    // full connectivity, every proposal
    directed.push_back(pack_word(3'b000, PAT_ALL, -100, 200, 300, 0, PROP_AB));
    directed.push_back(pack_word(3'b000, PAT_ALL, 100, -200, 300, 0, PROP_BC));
    directed.push_back(pack_word(3'b000, PAT_ALL, 100, 200, -300, 0, PROP_AC));
    directed.push_back(pack_word(3'b100, PAT_ALL, 256, 0, 0, 65535, PROP_NONE));
    // zero energy step
    directed.push_back(pack_word(3'b100, PAT_ALL, 700, 0, 0, 65535, PROP_AB));
    // step at and just below the underflow bound
    directed.push_back(pack_word(3'b000, PAT_ALL, 4096, 0, 0, 0, PROP_AB));
    directed.push_back(pack_word(3'b000, PAT_ALL, 4095, 0, 0, 0, PROP_AB));
    // smallest step against both draw extremes
    directed.push_back(pack_word(3'b000, PAT_ALL, 0, 1, 0, 65535, PROP_BC));
    directed.push_back(pack_word(3'b000, PAT_ALL, 0, 1, 0, 0, PROP_BC));
    // one kT step right around exp(-1)
    directed.push_back(pack_word(3'b000, PAT_ALL, 0, 0, 256, 24000, PROP_AC));
    directed.push_back(pack_word(3'b000, PAT_ALL, 0, 0, 256, 24200, PROP_AC));
    // several bonds at the energy extremes
    directed.push_back(pack_word(3'b111, PAT_ALL, -32768, -32768, -32768, 0, PROP_AB));
    directed.push_back(pack_word(3'b111, PAT_ALL, 32767, 32767, 32767, 65535, PROP_NONE));
    directed.push_back(pack_word(3'b110, PAT_NO_AB, 32767, -32768, 0, 0, PROP_AC));
    // bond on a link that cannot bond
    directed.push_back(pack_word(3'b100, PAT_NO_AB, -300, 100, 0, 30000, PROP_BC));
    directed.push_back(pack_word(3'b001, PAT_NO_AC, 0, 0, -1000, 40000, PROP_NONE));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_word(directed[i]);
    drain_results();

    for (int unsigned n = 0; n < RandomWords; n++) begin
      if (n % 150 == 0) begin
        calm_send = ($urandom_range(0, 3) == 0);
        calm_recv = ($urandom_range(0, 3) == 0);
      end
      if (n == RandomWords / 2) drain_results();
      send_word(random_word());
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_updates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_updates.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/mtbu_pkg.sv
design/mtbu_in_if.sv
design/mtbu_out_if.sv
design/mtbu_front.sv
design/mtbu_term.sv
design/mtbu_square.sv
design/metropolis_triplet_bond_update_core.sv
design/mtbu_checker.sv
sim/metropolis_triplet_bond_update_core_tb.sv
